// ===== rtl/fdlx_pkg.sv =====
// ----------------------------------------------------------------------------
// fdlx_pkg
// Shared widths, constants and controller/datapath interface types for the
// stereo feedback delay line with crossfade.
// ----------------------------------------------------------------------------
package fdlx_pkg;

  localparam int DEPTH_DEFAULT       = 65536;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  // Port field widths
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 19;
  localparam int WEIGHT_W = 17;
  localparam int DELAY_W  = 17;
  localparam int SPREAD_W = 17;
  localparam int SIZE_W   = 17;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_DELAY_SIZE = 1'b0;
  localparam logic REG_STEREO     = 1'b1;

  // Fixed-point constants
  localparam int Q_ONE    = 65536;
  localparam int Q_HALF   = 32768;
  localparam int TAP_STEP = 4;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic tap_mul;
    logic tap_upd;
    logic rd_en;
    logic mix;
    logic ysat;
    logic fbm;
    logic wb;
    logic byp_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic bypass;
  } status_t;

endpackage

// ===== rtl/feedback_delay_line_crossfade.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_line_crossfade
// Stereo feedback delay line on two ring stores with a crossfade between an
// old and a new read tap, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Sequence: a plain request steps from acceptance through the crossfade
//   multiply, saturation, feedback multiply and store write-back; retime adds
//   the tap multiply and tap update first; bypass (ring size zero) loads the
//   input straight into the result register. One request at a time: a new one
//   is taken only once the result is loaded, which waits for a free register.
// Reset: a clearing pass writes zero to every store entry, with in_ready low;
//   register writes are taken throughout.
module feedback_delay_line_crossfade #(
  parameter int DEPTH       = fdlx_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = fdlx_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fdlx_pkg::ADDR_W-1:0]           paddr,
  input  logic [fdlx_pkg::DATA_W-1:0]           pwdata,
  output logic [fdlx_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fdlx_pkg::SAMPLE_W-1:0]  left_in,
  input  logic signed [fdlx_pkg::SAMPLE_W-1:0]  right_in,
  input  logic signed [fdlx_pkg::GAIN_W-1:0]    feedback_gain,
  input  logic [fdlx_pkg::WEIGHT_W-1:0]         fade_weight,
  input  logic                                  retime,
  input  logic [fdlx_pkg::DELAY_W-1:0]          left_delay,
  input  logic [fdlx_pkg::DELAY_W-1:0]          right_delay,
  input  logic signed [fdlx_pkg::SPREAD_W-1:0]  spread,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fdlx_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [fdlx_pkg::SAMPLE_W-1:0]  right_out
);

  logic [fdlx_pkg::SIZE_W-1:0] delay_size;
  logic                        stereo_enable;
  logic                        reg_wr;
  logic                        size_write;

  fdlx_pkg::cmd_t    cmd;
  fdlx_pkg::status_t status;

  assign pready     = 1'b1;
  assign reg_wr     = psel && penable && pwrite;
  assign size_write = reg_wr && (paddr[2] == fdlx_pkg::REG_DELAY_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_size    <= '0;
      stereo_enable <= 1'b1;
    end else if (reg_wr) begin
      if (paddr[2] == fdlx_pkg::REG_DELAY_SIZE) begin
        delay_size <= pwdata[fdlx_pkg::SIZE_W-1:0];
      end else begin
        stereo_enable <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fdlx_pkg::REG_STEREO) begin
      prdata = fdlx_pkg::DATA_W'(stereo_enable);
    end else begin
      prdata = fdlx_pkg::DATA_W'(delay_size);
    end
  end

  fdlx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .retime    (retime),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fdlx_datapath #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .delay_size    (delay_size),
    .stereo_enable (stereo_enable),
    .size_write    (size_write),
    .left_in       (left_in),
    .right_in      (right_in),
    .feedback_gain (feedback_gain),
    .fade_weight   (fade_weight),
    .left_delay    (left_delay),
    .right_delay   (right_delay),
    .spread        (spread),
    .left_out      (left_out),
    .right_out     (right_out)
  );

endmodule

// ===== rtl/fdlx_ram.sv =====
// ----------------------------------------------------------------------------
// fdlx_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fdlx_ram #(
  parameter int WIDTH = fdlx_pkg::SAMPLE_BITS_DEFAULT,
  parameter int DEPTH = fdlx_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/fdlx_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdlx_ctrl
// Sequencer: clearing pass after reset, then one request at a time through
// tap update on retime, tap read, crossfade, feedback, write-back; or bypass.
// ----------------------------------------------------------------------------
module fdlx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              retime,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fdlx_pkg::status_t status,
  output fdlx_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BYP   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_TAP   = 4'd4;
  localparam logic [3:0] S_MIX   = 4'd5;
  localparam logic [3:0] S_YSAT  = 4'd6;
  localparam logic [3:0] S_FBM   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        // keep reading at the current taps so a plain request can skip ahead
        cmd.rd_en  = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (status.bypass)  state_next = S_BYP;
          else if (retime)    state_next = S_MUL;
          else                state_next = S_MIX;
        end
      end
      S_BYP: begin
        if (out_free) begin
          cmd.byp_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.tap_mul = 1'b1;
        state_next  = S_TAP;
      end
      S_TAP: begin
        cmd.tap_upd = 1'b1;
        cmd.rd_en   = 1'b1;
        state_next  = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_YSAT;
      end
      S_YSAT: begin
        cmd.ysat   = 1'b1;
        state_next = S_FBM;
      end
      S_FBM: begin
        cmd.fbm    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.wb     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.wb || cmd.byp_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("clearing pass not started after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.wb || cmd.byp_out) |-> (!out_valid || out_ready))
    else $error("result register loaded while holding an untaken result");

  a_retime_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !status.bypass && retime) |=> state == S_MUL)
    else $error("retime request skipped the tap update");

  a_wb_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && out_free) |=> (out_valid && state == S_IDLE))
    else $error("write-back did not deliver a result");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !(cmd.wb || cmd.load_in))
    else $error("store write or request accepted during clearing pass");

endmodule

// ===== rtl/fdlx_datapath.sv =====
// ----------------------------------------------------------------------------
// fdlx_datapath
// Ring stores, write and tap pointers, tap multipliers, crossfade and
// feedback arithmetic, result register.
// ----------------------------------------------------------------------------
module fdlx_datapath #(
  parameter int DEPTH       = fdlx_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = fdlx_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fdlx_pkg::cmd_t                        cmd,
  output fdlx_pkg::status_t                     status,
  input  logic [fdlx_pkg::SIZE_W-1:0]           delay_size,
  input  logic                                  stereo_enable,
  input  logic                                  size_write,
  input  logic signed [fdlx_pkg::SAMPLE_W-1:0]  left_in,
  input  logic signed [fdlx_pkg::SAMPLE_W-1:0]  right_in,
  input  logic signed [fdlx_pkg::GAIN_W-1:0]    feedback_gain,
  input  logic [fdlx_pkg::WEIGHT_W-1:0]         fade_weight,
  input  logic [fdlx_pkg::DELAY_W-1:0]          left_delay,
  input  logic [fdlx_pkg::DELAY_W-1:0]          right_delay,
  input  logic signed [fdlx_pkg::SPREAD_W-1:0]  spread,
  output logic signed [fdlx_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [fdlx_pkg::SAMPLE_W-1:0]  right_out
);

  localparam int AW    = $clog2(DEPTH);
  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = (AW + 1 > fdlx_pkg::SIZE_W) ? AW + 1 : fdlx_pkg::SIZE_W;
  localparam int WW    = fdlx_pkg::WEIGHT_W;
  localparam int DW    = fdlx_pkg::DELAY_W;
  localparam int XW    = fdlx_pkg::SAMPLE_W;
  localparam int PRODW = 2 * DW;
  localparam int NW    = PRODW - 15;
  localparam int TW    = (NW > CW) ? NW : CW;
  localparam int WIDE  = SB + WW + 4;

  localparam logic signed [WIDE-1:0] SB_MAX  = $signed((WIDE'(1) << (SB - 1)) - WIDE'(1));
  localparam logic signed [WIDE-1:0] SB_MIN  = ~SB_MAX;
  localparam logic signed [WIDE-1:0] OUT_MAX = $signed((WIDE'(1) << (XW - 1)) - WIDE'(1));
  localparam logic signed [WIDE-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [fdlx_pkg::GAIN_W-1:0] G_LIM =
    fdlx_pkg::GAIN_W'(fdlx_pkg::Q_ONE);
  localparam logic signed [DW:0] S_LIM = (DW + 1)'(fdlx_pkg::Q_HALF);

  function automatic logic signed [SB-1:0] sat_sb(input logic signed [WIDE-1:0] v);
    if (v > SB_MAX)      sat_sb = SB_MAX[SB-1:0];
    else if (v < SB_MIN) sat_sb = SB_MIN[SB-1:0];
    else                 sat_sb = v[SB-1:0];
  endfunction

  function automatic logic signed [XW-1:0] sat_out(input logic signed [WIDE-1:0] v);
    if (v > OUT_MAX)      sat_out = OUT_MAX[XW-1:0];
    else if (v < OUT_MIN) sat_out = OUT_MIN[XW-1:0];
    else                  sat_out = v[XW-1:0];
  endfunction

  function automatic logic [AW-1:0] make_tap(input logic [PRODW-1:0] p,
                                             input logic [AW-1:0]    wp_v,
                                             input logic [CW-1:0]    size);
    logic [TW-1:0] n;
    logic [TW-1:0] lim;
    logic [TW-1:0] wpx;
    logic [TW-1:0] sz;
    // drop 15 fraction bits and round down to a multiple of four
    n   = TW'({p[PRODW-1:17], 2'b00});
    sz  = TW'(size);
    lim = sz - TW'(fdlx_pkg::TAP_STEP);
    wpx = TW'(wp_v);
    if (n > lim) n = lim;
    if (n > wpx) make_tap = AW'(wpx + sz - n);
    else         make_tap = AW'(wpx - n);
  endfunction

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                            input logic [CW-1:0] size);
    logic [CW-1:0] q;
    q = CW'(p) + CW'(1);
    advance = (q >= size) ? '0 : AW'(q);
  endfunction

  // effective ring size
  logic [CW-1:0] size_ext;
  logic [CW-1:0] size_clip;
  logic [CW-1:0] size_eff;

  assign size_ext  = CW'(delay_size);
  assign size_clip = (size_ext > CW'(DEPTH)) ? CW'(DEPTH) : size_ext;
  assign size_eff  = {size_clip[CW-1:2], 2'b00};

  // clearing pass counter
  logic [AW-1:0] clr_cnt;

  assign status.clear_last = (clr_cnt == AW'(DEPTH - 1));
  assign status.bypass     = (size_eff == '0);

  // input clamps
  logic [WW-1:0]         g_cl;
  logic [WW-1:0]         w_cl;
  logic signed [DW:0]    s_ext;
  logic signed [DW:0]    s_cl;
  logic signed [DW:0]    fl_full;
  logic signed [DW:0]    fr_full;

  always_comb begin
    if (feedback_gain[fdlx_pkg::GAIN_W-1]) g_cl = '0;
    else if (feedback_gain > G_LIM)        g_cl = WW'(fdlx_pkg::Q_ONE);
    else                                   g_cl = feedback_gain[WW-1:0];
    w_cl  = (fade_weight > WW'(fdlx_pkg::Q_ONE)) ? WW'(fdlx_pkg::Q_ONE) : fade_weight;
    s_ext = (DW + 1)'(spread);
    if (s_ext > S_LIM)       s_cl = S_LIM;
    else if (s_ext < -S_LIM) s_cl = -S_LIM;
    else                     s_cl = s_ext;
    fl_full = S_LIM - s_cl;
    fr_full = S_LIM + s_cl;
  end

  logic signed [XW-1:0] x_l;
  logic signed [XW-1:0] x_r;
  logic [WW-1:0]        g_q;
  logic [WW-1:0]        w_q;
  logic [DW-1:0]        dl_q;
  logic [DW-1:0]        dr_q;
  logic [DW-1:0]        fl_q;
  logic [DW-1:0]        fr_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_l  <= left_in;
      x_r  <= right_in;
      g_q  <= g_cl;
      w_q  <= w_cl;
      dl_q <= left_delay;
      dr_q <= right_delay;
      fl_q <= fl_full[DW-1:0];
      fr_q <= fr_full[DW-1:0];
    end
  end

  // tap products
  logic [PRODW-1:0] pl;
  logic [PRODW-1:0] pr;

  always_ff @(posedge clk) begin
    if (cmd.tap_mul) begin
      pl <= dl_q * fl_q;
      pr <= dr_q * fr_q;
    end
  end

  // pointers
  logic [AW-1:0] wp;
  logic [AW-1:0] lo;
  logic [AW-1:0] ln;
  logic [AW-1:0] ro;
  logic [AW-1:0] rn;
  logic [AW-1:0] tap_l_new;
  logic [AW-1:0] tap_r_new;

  assign tap_l_new = make_tap(pl, wp, size_eff);
  assign tap_r_new = make_tap(pr, wp, size_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wp      <= '0;
      lo      <= '0;
      ln      <= '0;
      ro      <= '0;
      rn      <= '0;
    end else begin
      if (cmd.clear_wr) clr_cnt <= clr_cnt + AW'(1);
      if (size_write) begin
        wp <= '0;
        lo <= '0;
        ln <= '0;
        ro <= '0;
        rn <= '0;
      end else begin
        if (cmd.tap_upd) begin
          lo <= ln;
          ln <= tap_l_new;
          if (stereo_enable) begin
            ro <= rn;
            rn <= tap_r_new;
          end
        end
        if (cmd.wb) begin
          wp <= advance(wp, size_eff);
          lo <= advance(lo, size_eff);
          ln <= advance(ln, size_eff);
          if (stereo_enable) begin
            ro <= advance(ro, size_eff);
            rn <= advance(rn, size_eff);
          end
        end
      end
    end
  end

  // stores
  logic [AW-1:0] ra_l;
  logic [AW-1:0] rb_l;
  logic [AW-1:0] ra_r;
  logic [AW-1:0] rb_r;
  logic [AW-1:0] waddr;
  logic [SB-1:0] rd_lo;
  logic [SB-1:0] rd_ln;
  logic [SB-1:0] rd_ro;
  logic [SB-1:0] rd_rn;
  logic [SB-1:0] wd_l;
  logic [SB-1:0] wd_r;
  logic          we_l;
  logic          we_r;
  logic signed [SB-1:0] st_l;
  logic signed [SB-1:0] st_r;

  assign ra_l  = cmd.tap_upd ? ln : lo;
  assign rb_l  = cmd.tap_upd ? tap_l_new : ln;
  assign ra_r  = (cmd.tap_upd && stereo_enable) ? rn : ro;
  assign rb_r  = (cmd.tap_upd && stereo_enable) ? tap_r_new : rn;
  assign waddr = cmd.clear_wr ? clr_cnt : wp;
  assign wd_l  = cmd.clear_wr ? '0 : st_l;
  assign wd_r  = cmd.clear_wr ? '0 : st_r;
  assign we_l  = cmd.clear_wr || cmd.wb;
  assign we_r  = cmd.clear_wr || (cmd.wb && stereo_enable);

  fdlx_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_left_store (
    .clk     (clk),
    .we      (we_l),
    .waddr   (waddr),
    .wdata   (wd_l),
    .re      (cmd.rd_en),
    .raddr_a (ra_l),
    .raddr_b (rb_l),
    .rdata_a (rd_lo),
    .rdata_b (rd_ln)
  );

  fdlx_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_right_store (
    .clk     (clk),
    .we      (we_r),
    .waddr   (waddr),
    .wdata   (wd_r),
    .re      (cmd.rd_en),
    .raddr_a (ra_r),
    .raddr_b (rb_r),
    .rdata_a (rd_ro),
    .rdata_b (rd_rn)
  );

  // crossfade: y = new + floor(w * (old - new) / 2^16)
  logic signed [SB-1:0] xs_l;
  logic signed [SB-1:0] xs_r;
  logic signed [SB-1:0] old_l;
  logic signed [SB-1:0] new_l;
  logic signed [SB-1:0] old_r;
  logic signed [SB-1:0] new_r;
  logic signed [SB:0]   diff_l;
  logic signed [SB:0]   diff_r;

  always_comb begin
    xs_l = sat_sb(WIDE'(x_l));
    xs_r = sat_sb(WIDE'(x_r));
    // a tap at the write position sees the incoming sample
    old_l  = (lo == wp) ? xs_l : rd_lo;
    new_l  = (ln == wp) ? xs_l : rd_ln;
    old_r  = (ro == wp) ? xs_r : rd_ro;
    new_r  = (rn == wp) ? xs_r : rd_rn;
    diff_l = {old_l[SB-1], old_l} - {new_l[SB-1], new_l};
    diff_r = {old_r[SB-1], old_r} - {new_r[SB-1], new_r};
  end

  logic signed [SB+WW+1:0] mp_l;
  logic signed [SB+WW+1:0] mp_r;
  logic signed [SB-1:0]    nv_l;
  logic signed [SB-1:0]    nv_r;
  logic signed [SB-1:0]    y_l;
  logic signed [SB-1:0]    y_r;
  logic signed [SB+WW:0]   fb_l;
  logic signed [SB+WW:0]   fb_r;

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      mp_l <= diff_l * $signed({1'b0, w_q});
      mp_r <= diff_r * $signed({1'b0, w_q});
      nv_l <= new_l;
      nv_r <= new_r;
    end
    if (cmd.ysat) begin
      y_l <= sat_sb(WIDE'(nv_l) + (WIDE'(mp_l) >>> 16));
      y_r <= sat_sb(WIDE'(nv_r) + (WIDE'(mp_r) >>> 16));
    end
    if (cmd.fbm) begin
      fb_l <= y_l * $signed({1'b0, g_q});
      fb_r <= y_r * $signed({1'b0, g_q});
    end
  end

  assign st_l = sat_sb(WIDE'(x_l) + (WIDE'(fb_l) >>> 16));
  assign st_r = sat_sb(WIDE'(x_r) + (WIDE'(fb_r) >>> 16));

  // result register
  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      left_out  <= sat_out(WIDE'(y_l));
      right_out <= stereo_enable ? sat_out(WIDE'(y_r)) : '0;
    end else if (cmd.byp_out) begin
      left_out  <= x_l;
      right_out <= stereo_enable ? x_r : '0;
    end
  end

endmodule

// ===== tb/feedback_delay_line_crossfade_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_delay_line_crossfade_tb
// Self-checking bench for the stereo feedback delay line. A behavioral copy of
// the ring stores, taps and crossfade math predicts every result as its request
// is accepted. Directed requests cover bypass, zero and clamped delays, mono
// mode and size rewrites. Random crossfade sequences then follow under several
// ring sizes, with random stalls on both channels in all but one phase.
// ----------------------------------------------------------------------------
module feedback_delay_line_crossfade_tb;

  localparam int RING_DEPTH  = fdlx_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [fdlx_pkg::SAMPLE_W-1:0] left_in;
    logic signed [fdlx_pkg::SAMPLE_W-1:0] right_in;
    logic signed [fdlx_pkg::GAIN_W-1:0]   gain;
    logic [fdlx_pkg::WEIGHT_W-1:0]        weight;
    logic                                 retime;
    logic [fdlx_pkg::DELAY_W-1:0]         left_delay;
    logic [fdlx_pkg::DELAY_W-1:0]         right_delay;
    logic signed [fdlx_pkg::SPREAD_W-1:0] spread;
  } stereo_frame_t;

  typedef struct {
    logic signed [fdlx_pkg::SAMPLE_W-1:0] left;
    logic signed [fdlx_pkg::SAMPLE_W-1:0] right;
  } stereo_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fdlx_pkg::ADDR_W-1:0] paddr = '0;
  logic [fdlx_pkg::DATA_W-1:0] pwdata = '0;
  logic [fdlx_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [fdlx_pkg::SAMPLE_W-1:0] left_in = '0;
  logic signed [fdlx_pkg::SAMPLE_W-1:0] right_in = '0;
  logic signed [fdlx_pkg::GAIN_W-1:0] feedback_gain = '0;
  logic [fdlx_pkg::WEIGHT_W-1:0] fade_weight = '0;
  logic retime = 1'b0;
  logic [fdlx_pkg::DELAY_W-1:0] left_delay = '0;
  logic [fdlx_pkg::DELAY_W-1:0] right_delay = '0;
  logic signed [fdlx_pkg::SPREAD_W-1:0] spread = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [fdlx_pkg::SAMPLE_W-1:0] left_out;
  logic signed [fdlx_pkg::SAMPLE_W-1:0] right_out;

  // predicted block state
  logic signed [fdlx_pkg::SAMPLE_W-1:0] left_ring [RING_DEPTH];
  logic signed [fdlx_pkg::SAMPLE_W-1:0] right_ring [RING_DEPTH];
  int unsigned wr_pos, l_old, l_new, r_old, r_new;
  logic [fdlx_pkg::SIZE_W-1:0] size_reg;
  logic stereo_reg;

  stereo_out_t expected_out[$];
  stereo_out_t want;
  int errors = 0;
  int cycle_count = 0;
  bit steady = 0;

  feedback_delay_line_crossfade dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_in(left_in), .right_in(right_in), .feedback_gain(feedback_gain),
    .fade_weight(fade_weight), .retime(retime), .left_delay(left_delay),
    .right_delay(right_delay), .spread(spread),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_out(left_out), .right_out(right_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s at cycle %0d: expected %0d, got %0d", what, cycle_count, exp_v,
             got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected result, left_out", 0, longint'(left_out));
      end else begin
        want = expected_out.pop_front();
        if (left_out !== want.left)
          report_mismatch("left_out", longint'(want.left), longint'(left_out));
        if (right_out !== want.right)
          report_mismatch("right_out", longint'(want.right), longint'(right_out));
      end
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_sample(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic int unsigned ring_len();
    int unsigned sz;
    sz = (size_reg > RING_DEPTH) ? RING_DEPTH : 32'(size_reg);
    return sz & ~(fdlx_pkg::TAP_STEP - 1);
  endfunction

  function automatic int unsigned step_ptr(input int unsigned p, input int unsigned len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  // tap position delay*factor/2^15, rounded down to a multiple of four and clamped, samples behind the write pointer
  function automatic int unsigned tap_behind(input longint unsigned delay,
                                             input longint unsigned factor,
                                             input int unsigned len);
    longint unsigned n;
    n = (delay * factor) >> 15;
    n = n & ~longint'(fdlx_pkg::TAP_STEP - 1);
    if (n > 64'(len - fdlx_pkg::TAP_STEP)) n = 64'(len - fdlx_pkg::TAP_STEP);
    if (n > 64'(wr_pos)) return 32'(64'(wr_pos) + 64'(len) - n);
    return 32'(64'(wr_pos) - n);
  endfunction

  // write input, crossfade the two taps, write back with feedback, advance taps
  function automatic longint mix_channel(input bit right_side, input longint x,
                                         input longint w, input longint g,
                                         input int unsigned len);
    int unsigned o, n;
    longint a, b, y;
    o = right_side ? r_old : l_old;
    n = right_side ? r_new : l_new;
    if (right_side) right_ring[wr_pos] = fdlx_pkg::SAMPLE_W'(x);
    else left_ring[wr_pos] = fdlx_pkg::SAMPLE_W'(x);
    a = right_side ? longint'(right_ring[o]) : longint'(left_ring[o]);
    b = right_side ? longint'(right_ring[n]) : longint'(left_ring[n]);
    y = sat_sample((w * a + (fdlx_pkg::Q_ONE - w) * b) >>> 16);
    if (right_side) begin
      right_ring[wr_pos] = fdlx_pkg::SAMPLE_W'(sat_sample(x + ((y * g) >>> 16)));
      r_old = step_ptr(o, len);
      r_new = step_ptr(n, len);
    end else begin
      left_ring[wr_pos] = fdlx_pkg::SAMPLE_W'(sat_sample(x + ((y * g) >>> 16)));
      l_old = step_ptr(o, len);
      l_new = step_ptr(n, len);
    end
    return y;
  endfunction

  function automatic stereo_out_t predict_frame(input stereo_frame_t f);
    stereo_out_t r;
    longint xl, xr, g, w, s, yl, yr;
    int unsigned len;
    xl = longint'(f.left_in);
    xr = longint'(f.right_in);
    g = longint'(f.gain);
    w = longint'(f.weight);
    s = longint'(f.spread);
    len = ring_len();
    if (len == 0) begin
      r.left = f.left_in;
      r.right = stereo_reg ? f.right_in : '0;
      return r;
    end
    if (g < 0) g = 0;
    if (g > fdlx_pkg::Q_ONE) g = fdlx_pkg::Q_ONE;
    if (w > fdlx_pkg::Q_ONE) w = fdlx_pkg::Q_ONE;
    if (s < -fdlx_pkg::Q_HALF) s = -fdlx_pkg::Q_HALF;
    if (s > fdlx_pkg::Q_HALF) s = fdlx_pkg::Q_HALF;
    if (f.retime) begin
      l_old = l_new;
      l_new = tap_behind(64'(f.left_delay), fdlx_pkg::Q_HALF - s, len);
      if (stereo_reg) begin
        r_old = r_new;
        r_new = tap_behind(64'(f.right_delay), fdlx_pkg::Q_HALF + s, len);
      end
    end
    yl = mix_channel(1'b0, xl, w, g, len);
    yr = 0;
    if (stereo_reg) yr = mix_channel(1'b1, xr, w, g, len);
    wr_pos = step_ptr(wr_pos, len);
    r.left = yl[fdlx_pkg::SAMPLE_W-1:0];
    r.right = yr[fdlx_pkg::SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic apply_register(input logic idx, input logic [fdlx_pkg::DATA_W-1:0] value);
    if (idx == fdlx_pkg::REG_DELAY_SIZE) begin
      size_reg = value[fdlx_pkg::SIZE_W-1:0];
      wr_pos = 0;
      l_old = 0;
      l_new = 0;
      r_old = 0;
      r_new = 0;
    end else begin
      stereo_reg = value[0];
    end
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic write_register(input logic idx, input logic [fdlx_pkg::DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_register(idx, value);
  endtask

  task automatic send_frame(input stereo_frame_t f);
    if (!steady) begin
      while ($urandom_range(0, 99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    left_in <= f.left_in;
    right_in <= f.right_in;
    feedback_gain <= f.gain;
    fade_weight <= f.weight;
    retime <= f.retime;
    left_delay <= f.left_delay;
    right_delay <= f.right_delay;
    spread <= f.spread;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_out.push_back(predict_frame(f));
  endtask

  function automatic stereo_frame_t make_frame(input int l, input int r, input int g,
                                               input int w, input bit rt, input int dl,
                                               input int dr, input int s);
    stereo_frame_t f;
    f.left_in = fdlx_pkg::SAMPLE_W'(l);
    f.right_in = fdlx_pkg::SAMPLE_W'(r);
    f.gain = fdlx_pkg::GAIN_W'(g);
    f.weight = fdlx_pkg::WEIGHT_W'(w);
    f.retime = rt;
    f.left_delay = fdlx_pkg::DELAY_W'(dl);
    f.right_delay = fdlx_pkg::DELAY_W'(dr);
    f.spread = fdlx_pkg::SPREAD_W'(s);
    return f;
  endfunction

  function automatic logic signed [fdlx_pkg::SAMPLE_W-1:0] random_sample();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 2000) - 1000;
    return v[fdlx_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic [fdlx_pkg::DELAY_W-1:0] pick_delay(input int unsigned len);
    int unsigned top;
    top = len + len / 4 + 4;
    if (top > 131071) top = 131071;
    case ($urandom_range(0, 3))
      0: return fdlx_pkg::DELAY_W'($urandom_range(0, 16));
      3: return fdlx_pkg::DELAY_W'($urandom_range(0, 131071));
      default: return fdlx_pkg::DELAY_W'($urandom_range(0, top));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_bypass();
    // reset leaves the ring size at zero
    send_frame(make_frame(8388607, -8388608, 0, 0, 1, 65536, 0, 0));
    send_frame(make_frame(-8388608, 8388607, 131072, 65536, 0, 131071, 131071, -65536));
    write_register(fdlx_pkg::REG_STEREO, 0);
    send_frame(make_frame(-1, 1234567, -65536, 131071, 1, 5, 9, 65535));
    write_register(fdlx_pkg::REG_STEREO, 1);
    // size below one tap step rounds down to bypass
    write_register(fdlx_pkg::REG_DELAY_SIZE, 3);
    send_frame(make_frame(4242, -4242, 65536, 32768, 1, 4, 4, 0));
  endtask

  task automatic test_delay_taps();
    write_register(fdlx_pkg::REG_DELAY_SIZE, 16);
    // zero delay: the tap reads the sample just written
    send_frame(make_frame(8388607, -8388608, 0, 0, 1, 0, 0, 0));
    send_frame(make_frame(8388607, -8388608, 65536, 65536, 0, 0, 0, 0));
    send_frame(make_frame(-3000000, 3000000, 65536, 0, 0, 0, 0, 0));
    send_frame(make_frame(100000, -200000, 32768, 32768, 1, 8, 4, 0));
    // spread beyond one half clamps to full left or right
    send_frame(make_frame(-7777, 7777, 49152, 16384, 1, 8, 8, -65536));
    send_frame(make_frame(555555, -555555, 16384, 49152, 1, 8, 8, 65535));
    // delays past the ring clamp to size minus one step
    send_frame(make_frame(-8388608, 8388607, 131072, 0, 1, 131071, 65536, 0));
    send_frame(make_frame(12345, -12345, -262144, 131071, 1, 7, 3, 0));
  endtask

  task automatic test_mono();
    write_register(fdlx_pkg::REG_DELAY_SIZE, 8);
    write_register(fdlx_pkg::REG_STEREO, 0);
    send_frame(make_frame(1000000, 2000000, 65536, 0, 1, 4, 4, 0));
    send_frame(make_frame(-1000000, -2000000, 65536, 32768, 1, 0, 4, 16384));
    send_frame(make_frame(300000, 400000, 40000, 65536, 0, 0, 0, 0));
    write_register(fdlx_pkg::REG_STEREO, 1);
    // right taps still hold where mono left them
    send_frame(make_frame(-50000, 60000, 65536, 0, 0, 0, 0, 0));
    send_frame(make_frame(70000, -80000, 20000, 20000, 1, 4, 0, -16384));
  endtask

  task automatic test_size_rewrite();
    // pointers reset, stored samples stay
    write_register(fdlx_pkg::REG_DELAY_SIZE, 20);
    send_frame(make_frame(1, -1, 0, 65536, 1, 12, 12, 0));
    send_frame(make_frame(2, -2, 65536, 0, 0, 0, 0, 0));
    write_register(fdlx_pkg::REG_DELAY_SIZE, 65536);
    send_frame(make_frame(-9999, 9999, 65536, 0, 1, 65536, 131071, 0));
    write_register(fdlx_pkg::REG_DELAY_SIZE, 65535);
    send_frame(make_frame(8388607, 8388607, 65536, 0, 1, 65535, 65532, 32768));
  endtask

  task automatic run_fade_phase(input int unsigned len, input bit stereo_on,
                                input bit no_idle, input int unsigned count);
    int unsigned sent, steps, k;
    stereo_frame_t f;
    logic [fdlx_pkg::DELAY_W-1:0] dl, dr;
    int s, g;
    write_register(fdlx_pkg::REG_DELAY_SIZE, len);
    write_register(fdlx_pkg::REG_STEREO, 32'(stereo_on));
    steady = no_idle;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: every field at any value its width allows
        f.left_in = random_sample();
        f.right_in = random_sample();
        f.gain = fdlx_pkg::GAIN_W'($urandom);
        f.weight = fdlx_pkg::WEIGHT_W'($urandom);
        f.retime = 1'($urandom_range(0, 1));
        f.left_delay = fdlx_pkg::DELAY_W'($urandom);
        f.right_delay = fdlx_pkg::DELAY_W'($urandom);
        f.spread = fdlx_pkg::SPREAD_W'($urandom);
        send_frame(f);
        sent++;
      end else begin
        // retime, then ramp the old-tap weight down to zero
        steps = $urandom_range(1, 8);
        dl = pick_delay(len);
        dr = pick_delay(len);
        s = $urandom_range(0, 1) ? int'($urandom_range(0, 65536)) - 32768
                                 : int'($urandom_range(0, 131071)) - 65536;
        g = $urandom_range(0, 3) == 0 ? fdlx_pkg::Q_ONE
                                      : int'($urandom_range(0, 196608)) - 65536;
        for (k = 0; k <= steps && sent < count; k++) begin
          f.left_in = random_sample();
          f.right_in = random_sample();
          f.gain = fdlx_pkg::GAIN_W'(g);
          f.weight = fdlx_pkg::WEIGHT_W'(fdlx_pkg::Q_ONE - (fdlx_pkg::Q_ONE * k) / steps);
          f.retime = (k == 0);
          f.left_delay = k == 0 ? dl : fdlx_pkg::DELAY_W'($urandom);
          f.right_delay = k == 0 ? dr : fdlx_pkg::DELAY_W'($urandom);
          f.spread = fdlx_pkg::SPREAD_W'(s);
          send_frame(f);
          sent++;
        end
      end
    end
    steady = 0;
  endtask

  task automatic test_random();
    run_fade_phase(16, 1, 0, 66);
    run_fade_phase(4, 1, 0, 66);
    run_fade_phase(64, 0, 0, 66);
    run_fade_phase(65536, 1, 1, 66);
    run_fade_phase(40, 1, 0, 66);
    run_fade_phase(0, 1, 0, 66);
    run_fade_phase(65535, 1, 0, 66);
    run_fade_phase(12, 0, 0, 66);
  endtask

  initial begin
    size_reg = '0;
    stereo_reg = 1'b1;
    wr_pos = 0;
    l_old = 0;
    l_new = 0;
    r_old = 0;
    r_new = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      left_ring[i] = '0;
      right_ring[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_bypass();
    test_delay_taps();
    test_mono();
    test_size_rewrite();
    test_random();

    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
